// ----- hdl/wave_equation_stencil_update_assert.svh -----
// ---------------------------------------------------------------------------
// wave_equation_stencil_update_assert
// assertion macros shared by the stencil update block, empty for synthesis
// ---------------------------------------------------------------------------
`ifndef WAVE_EQUATION_STENCIL_UPDATE_ASSERT_SVH
`define WAVE_EQUATION_STENCIL_UPDATE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define WESU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// next-cycle implication
`define WESU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define WESU_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define WESU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/wesu_pkg.sv -----
// ---------------------------------------------------------------------------
// wesu_pkg
// shared types and constants of the wave equation stencil update
// ---------------------------------------------------------------------------
package wesu_pkg;

  localparam int VALUE_W     = 32;
  localparam int SIZE_W      = 7;
  localparam int POS_W       = 6;
  localparam int COUR_W      = 31;
  localparam int DT_W        = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 88;

  localparam int DEF_MAX_X = 64;
  localparam int DEF_MAX_Y = 64;
  localparam int DEF_MAX_Z = 64;
  localparam int DEF_SIZE  = 64;

  // arithmetic widths
  localparam int LAP_W   = VALUE_W + 3;        // signed second difference
  localparam int MAG_W   = VALUE_W + 2;        // its magnitude
  localparam int CMAG_W  = VALUE_W;            // charge magnitude
  localparam int COEF_W  = 2 * COUR_W;         // squared courant number
  localparam int DT2_W   = 2 * DT_W;           // squared time step
  localparam int LAP_SH  = 62;
  localparam int SRC_SH  = 49;
  localparam int TERM_W  = COEF_W + MAG_W - LAP_SH + 2;
  localparam int SRC_W   = DT2_W + CMAG_W - SRC_SH + 2;
  localparam int SUM_W   = SRC_W + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_SIZE    = 3'd0,
    CFG_Y_SIZE    = 3'd1,
    CFG_Z_SIZE    = 3'd2,
    CFG_COURANT_X = 3'd3,
    CFG_COURANT_Y = 3'd4,
    CFG_COURANT_Z = 3'd5,
    CFG_TIME_STEP = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] charge;
    logic signed [VALUE_W-1:0] previous_pot;
    logic signed [VALUE_W-1:0] current_pot;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] chg;
    logic signed [VALUE_W-1:0] prev;
  } center_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] xm;
    logic signed [VALUE_W-1:0] xp;
    logic signed [VALUE_W-1:0] ym;
    logic signed [VALUE_W-1:0] yp;
    logic signed [VALUE_W-1:0] zm;
    logic signed [VALUE_W-1:0] zp;
    logic signed [VALUE_W-1:0] c;
  } taps_t;

  typedef struct packed {
    logic             last;
    logic [POS_W-1:0] z;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] x;
  } pos_t;

  typedef struct packed {
    pos_t                      pos;
    logic signed [VALUE_W-1:0] swapped;
  } side_t;

  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v, int maxv);
    logic [SIZE_W-1:0] r;
    if (v < SIZE_W'(3)) begin
      r = SIZE_W'(3);
    end else if (int'(v) > maxv) begin
      r = SIZE_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- hdl/wesu_ram.sv -----
// ---------------------------------------------------------------------------
// wesu_ram
// single-port ram, read-first, registered read
// ---------------------------------------------------------------------------
module wesu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mem[addr] <= wdata;
      rdata_r   <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/wesu_delay.sv -----
// ---------------------------------------------------------------------------
// wesu_delay
// run-time length delay line on a circular ram pointer
// ---------------------------------------------------------------------------
module wesu_delay #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             restart,
  input  logic                             shift,
  input  logic [$clog2(DEPTH+1)-1:0]       len,
  input  logic [WIDTH-1:0]                 din,
  output logic [WIDTH-1:0]                 dout
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  logic [LW-1:0] ptr_r, ptr_nxt;

  // output register holds the beat written len shifts earlier
  always_comb begin
    ptr_nxt = ptr_r;
    if (restart) begin
      ptr_nxt = '0;
    end else if (shift) begin
      ptr_nxt = (ptr_r == len - LW'(1)) ? '0 : ptr_r + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else begin
      ptr_r <= ptr_nxt;
    end
  end

  wesu_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (shift),
    .addr  (ptr_r[AW-1:0]),
    .wdata (din),
    .rdata (dout)
  );

endmodule

// ----- hdl/wesu_window.sv -----
// ---------------------------------------------------------------------------
// wesu_window
// raster scan position and plane and row delay lines forming the stencil
// ---------------------------------------------------------------------------
module wesu_window #(
  parameter int MAX_X = 64,
  parameter int MAX_Y = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      restart,
  input  logic [wesu_pkg::SIZE_W-1:0] x_size,
  input  logic [wesu_pkg::SIZE_W-1:0] y_size,
  input  logic [wesu_pkg::SIZE_W-1:0] z_size,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  wesu_pkg::in_item_t        in_item,
  input  logic                      adv,
  output logic                      s1_v,
  output wesu_pkg::taps_t           taps,
  output wesu_pkg::center_t         ctr,
  output wesu_pkg::pos_t            pos
);

  import wesu_pkg::*;

  localparam int PD  = MAX_X * MAX_Y;
  localparam int PLW = $clog2(PD + 1);
  localparam int RLW = $clog2(MAX_X + 1);

  logic [2*SIZE_W-1:0] plane_prod;
  logic [PLW-1:0]      plane_r;
  logic [PLW-1:0]      len_a, len_b;
  logic [RLW-1:0]      len_row;
  logic                accept;

  logic [SIZE_W-1:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic              interior, last;
  logic              s1_v_r;
  pos_t              pos_r;
  logic signed [VALUE_W-1:0] m1, m2, m3, m4, c_r, cm_r, zp_r;
  center_t           ctr_q;

  assign plane_prod = x_size * y_size;

  always_ff @(posedge clk) begin
    plane_r <= PLW'(plane_prod);
  end

  assign len_a   = plane_r - PLW'(x_size);
  assign len_b   = len_a - PLW'(1);
  assign len_row = RLW'(x_size) - RLW'(2);

  assign in_ready = !s1_v_r || adv;
  assign accept   = in_valid && in_ready;

  // scan position of the arriving beat
  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (restart) begin
      x_nxt = '0;
      y_nxt = '0;
      z_nxt = '0;
    end else if (accept) begin
      if (x_r + SIZE_W'(1) >= x_size) begin
        x_nxt = '0;
        if (y_r + SIZE_W'(1) >= y_size) begin
          y_nxt = '0;
          z_nxt = (z_r + SIZE_W'(1) >= z_size) ? '0 : z_r + SIZE_W'(1);
        end else begin
          y_nxt = y_r + SIZE_W'(1);
        end
      end else begin
        x_nxt = x_r + SIZE_W'(1);
      end
    end
  end

  assign interior = (z_r >= SIZE_W'(2)) && (y_r >= SIZE_W'(1)) &&
                    (y_r <= y_size - SIZE_W'(2)) && (x_r >= SIZE_W'(1)) &&
                    (x_r <= x_size - SIZE_W'(2));
  assign last = (x_r == x_size - SIZE_W'(2)) && (y_r == y_size - SIZE_W'(2)) &&
                (z_r == z_size - SIZE_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= '0;
      y_r    <= '0;
      z_r    <= '0;
      s1_v_r <= 1'b0;
    end else begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      if (accept) begin
        s1_v_r <= interior;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_r.x    <= POS_W'(x_r);
      pos_r.y    <= POS_W'(y_r);
      pos_r.z    <= POS_W'(z_r - SIZE_W'(1));
      pos_r.last <= last;
      zp_r       <= in_item.current_pot;
      c_r        <= m2;
      cm_r       <= c_r;
    end
  end

  // tap chain: yp, xp, c, xm, ym, zm
  wesu_delay #(.WIDTH(VALUE_W), .DEPTH(PD)) u_d_yp (
    .clk(clk), .rst_n(rst_n), .restart(restart), .shift(accept),
    .len(len_a), .din(in_item.current_pot), .dout(m1)
  );

  wesu_delay #(.WIDTH(VALUE_W), .DEPTH(MAX_X)) u_d_xp (
    .clk(clk), .rst_n(rst_n), .restart(restart), .shift(accept),
    .len(len_row), .din(m1), .dout(m2)
  );

  wesu_delay #(.WIDTH(VALUE_W), .DEPTH(MAX_X)) u_d_ym (
    .clk(clk), .rst_n(rst_n), .restart(restart), .shift(accept),
    .len(len_row), .din(cm_r), .dout(m3)
  );

  wesu_delay #(.WIDTH(VALUE_W), .DEPTH(PD)) u_d_zm (
    .clk(clk), .rst_n(rst_n), .restart(restart), .shift(accept),
    .len(len_b), .din(m3), .dout(m4)
  );

  wesu_delay #(.WIDTH(2*VALUE_W), .DEPTH(PD)) u_d_ctr (
    .clk(clk), .rst_n(rst_n), .restart(restart), .shift(accept),
    .len(plane_r), .din({in_item.charge, in_item.previous_pot}), .dout(ctr_q)
  );

  assign taps.zp = zp_r;
  assign taps.yp = m1;
  assign taps.xp = m2;
  assign taps.c  = c_r;
  assign taps.xm = cm_r;
  assign taps.ym = m3;
  assign taps.zm = m4;
  assign ctr     = ctr_q;
  assign pos     = pos_r;
  assign s1_v    = s1_v_r;

endmodule

// ----- hdl/wesu_term.sv -----
// ---------------------------------------------------------------------------
// wesu_term
// two-stage coefficient times magnitude, rounded shift, sign restored
// ---------------------------------------------------------------------------
module wesu_term #(
  parameter int CW    = 62,
  parameter int MW    = 34,
  parameter int SHIFT = 62
) (
  input  logic                           clk,
  input  logic                           en_a,
  input  logic                           en_b,
  input  logic [CW-1:0]                  coef,
  input  logic [MW-1:0]                  mag,
  input  logic                           neg,
  output logic signed [CW+MW-SHIFT+1:0]  term
);

  localparam int HW = CW / 2;
  localparam int PW = CW + MW;
  localparam int QW = CW + MW - SHIFT + 1;
  localparam int OW = QW + 1;

  logic [CW-HW+MW-1:0] pp_hi_r;
  logic [HW+MW-1:0]    pp_lo_r;
  logic                neg_r;
  logic [PW-1:0]       prod;
  logic [QW-1:0]       q;
  logic signed [OW-1:0] sq, term_r;

  // split product so each multiplier stays near 32 by 32
  always_ff @(posedge clk) begin
    if (en_a) begin
      pp_hi_r <= coef[CW-1:HW] * mag;
      pp_lo_r <= coef[HW-1:0] * mag;
      neg_r   <= neg;
    end
  end

  assign prod = (PW'(pp_hi_r) << HW) + PW'(pp_lo_r);
  // round half up on the magnitude
  assign q  = QW'(prod[PW-1:SHIFT]) + QW'(prod[SHIFT-1]);
  assign sq = signed'({1'b0, q});

  always_ff @(posedge clk) begin
    if (en_b) begin
      term_r <= neg_r ? -sq : sq;
    end
  end

  assign term = term_r;

endmodule

// ----- hdl/wave_equation_stencil_update.sv -----
// result of centre (x,y,z) follows the beat of point (x,y,z+1) down the pipeline
// throughput: one grid point per cycle while out_tready does not stall the pipeline,
//   set by the single-port delay rams, each read and written once per accepted beat
// reset: synchronous active-low rst_n clears scan position, ram pointers and
//   valid bits; delay ram contents stay undefined until the sweep fills them
// ---------------------------------------------------------------------------
// wave_equation_stencil_update
// leapfrog step of the 3d wave equation with a 7-point stencil and source
// ---------------------------------------------------------------------------
`include "wave_equation_stencil_update_assert.svh"

module wave_equation_stencil_update #(
  parameter int MAX_X = wesu_pkg::DEF_MAX_X,
  parameter int MAX_Y = wesu_pkg::DEF_MAX_Y,
  parameter int MAX_Z = wesu_pkg::DEF_MAX_Z
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wesu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wesu_pkg::CFG_DATA_W-1:0]    cfg_data,
  // grid point stream: current_pot, previous_pot, charge
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [wesu_pkg::IN_TDATA_W-1:0]    in_tdata,
  // result stream: next_pot, swapped_pot, x_pos, y_pos, z_pos, zero pad
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [wesu_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tlast
);

  import wesu_pkg::*;

  // configuration registers
  logic [SIZE_W-1:0] x_size_r, y_size_r, z_size_r;
  logic [COUR_W-1:0] cx_r, cy_r, cz_r;
  logic [DT_W-1:0]   dt_r;
  logic              restart;
  logic [COEF_W-1:0] cx2_r, cy2_r, cz2_r;
  logic [DT2_W-1:0]  dt2_r;

  assign cfg_ready = 1'b1;
  // any size write restarts the sweep at the origin
  assign restart = cfg_valid && ((cfg_index == CFG_X_SIZE) || (cfg_index == CFG_Y_SIZE) ||
                                 (cfg_index == CFG_Z_SIZE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_size_r <= clamp_size(SIZE_W'(DEF_SIZE), MAX_X);
      y_size_r <= clamp_size(SIZE_W'(DEF_SIZE), MAX_Y);
      z_size_r <= clamp_size(SIZE_W'(DEF_SIZE), MAX_Z);
      cx_r     <= '0;
      cy_r     <= '0;
      cz_r     <= '0;
      dt_r     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_X_SIZE:    x_size_r <= clamp_size(cfg_data[SIZE_W-1:0], MAX_X);
        CFG_Y_SIZE:    y_size_r <= clamp_size(cfg_data[SIZE_W-1:0], MAX_Y);
        CFG_Z_SIZE:    z_size_r <= clamp_size(cfg_data[SIZE_W-1:0], MAX_Z);
        CFG_COURANT_X: cx_r     <= cfg_data[COUR_W-1:0];
        CFG_COURANT_Y: cy_r     <= cfg_data[COUR_W-1:0];
        CFG_COURANT_Z: cz_r     <= cfg_data[COUR_W-1:0];
        CFG_TIME_STEP: dt_r     <= cfg_data[DT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // squared coefficients, registered and refreshed every cycle
  always_ff @(posedge clk) begin
    cx2_r <= cx_r * cx_r;
    cy2_r <= cy_r * cy_r;
    cz2_r <= cz_r * cz_r;
    dt2_r <= dt_r * dt_r;
  end

  // pipeline advance chain, output register last
  logic v2_r, v3_r, v4_r, out_v_r;
  logic adv2, adv3, adv4, adv5;
  logic s1_v;

  assign adv5 = !out_v_r || out_tready;
  assign adv4 = !v4_r || adv5;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;

  // stage 1: stencil window
  in_item_t in_item;
  taps_t    taps;
  center_t  ctr;
  pos_t     pos;

  assign in_item = in_item_t'(in_tdata);

  wesu_window #(
    .MAX_X (MAX_X),
    .MAX_Y (MAX_Y)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (restart),
    .x_size   (x_size_r),
    .y_size   (y_size_r),
    .z_size   (z_size_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .adv      (adv2),
    .s1_v     (s1_v),
    .taps     (taps),
    .ctr      (ctr),
    .pos      (pos)
  );

  // stage 2: second differences, magnitudes, 2c - prev
  logic signed [LAP_W-1:0] two_c, lx, ly, lz, base;
  logic signed [VALUE_W:0] chg_w;
  logic [MAG_W-1:0]  mx_r, my_r, mz_r;
  logic [CMAG_W-1:0] mc_r;
  logic              nx_r, ny_r, nz_r, nc_r;
  logic signed [LAP_W-1:0] base2_r, base3_r, base4_r;
  side_t             side2_r, side3_r, side4_r;

  assign two_c = LAP_W'(taps.c) <<< 1;
  assign lx    = LAP_W'(taps.xm) + LAP_W'(taps.xp) - two_c;
  assign ly    = LAP_W'(taps.ym) + LAP_W'(taps.yp) - two_c;
  assign lz    = LAP_W'(taps.zm) + LAP_W'(taps.zp) - two_c;
  assign base  = two_c - LAP_W'(ctr.prev);
  assign chg_w = (VALUE_W+1)'(ctr.chg);

  always_ff @(posedge clk) begin
    if (adv2) begin
      mx_r <= MAG_W'(lx[LAP_W-1] ? -lx : lx);
      my_r <= MAG_W'(ly[LAP_W-1] ? -ly : ly);
      mz_r <= MAG_W'(lz[LAP_W-1] ? -lz : lz);
      mc_r <= CMAG_W'(chg_w[VALUE_W] ? -chg_w : chg_w);
      nx_r <= lx[LAP_W-1];
      ny_r <= ly[LAP_W-1];
      nz_r <= lz[LAP_W-1];
      nc_r <= chg_w[VALUE_W];
      base2_r         <= base;
      side2_r.pos     <= pos;
      side2_r.swapped <= taps.c;
    end
    if (adv3) begin
      base3_r <= base2_r;
      side3_r <= side2_r;
    end
    if (adv4) begin
      base4_r <= base3_r;
      side4_r <= side3_r;
    end
  end

  // stages 3 and 4: scaled terms
  logic signed [TERM_W-1:0] tx, ty, tz;
  logic signed [SRC_W-1:0]  ts;

  wesu_term #(.CW(COEF_W), .MW(MAG_W), .SHIFT(LAP_SH)) u_term_x (
    .clk(clk), .en_a(adv3), .en_b(adv4), .coef(cx2_r), .mag(mx_r), .neg(nx_r), .term(tx)
  );
  wesu_term #(.CW(COEF_W), .MW(MAG_W), .SHIFT(LAP_SH)) u_term_y (
    .clk(clk), .en_a(adv3), .en_b(adv4), .coef(cy2_r), .mag(my_r), .neg(ny_r), .term(ty)
  );
  wesu_term #(.CW(COEF_W), .MW(MAG_W), .SHIFT(LAP_SH)) u_term_z (
    .clk(clk), .en_a(adv3), .en_b(adv4), .coef(cz2_r), .mag(mz_r), .neg(nz_r), .term(tz)
  );
  wesu_term #(.CW(DT2_W), .MW(CMAG_W), .SHIFT(SRC_SH)) u_term_src (
    .clk(clk), .en_a(adv3), .en_b(adv4), .coef(dt2_r), .mag(mc_r), .neg(nc_r), .term(ts)
  );

  // stage 5: sum, saturate, output register
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (VALUE_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  logic signed [SUM_W-1:0]   sum;
  logic signed [VALUE_W-1:0] next_pot;
  side_t                     out_side_r;
  logic signed [VALUE_W-1:0] next_pot_r;

  assign sum = SUM_W'(base4_r) + SUM_W'(tx) + SUM_W'(ty) + SUM_W'(tz) + SUM_W'(ts);

  always_comb begin
    if (sum > SAT_HI) begin
      next_pot = VALUE_W'(SAT_HI);
    end else if (sum < SAT_LO) begin
      next_pot = VALUE_W'(SAT_LO);
    end else begin
      next_pot = VALUE_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv2) begin
        v2_r <= s1_v;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
      if (adv4) begin
        v4_r <= v3_r;
      end
      if (adv5) begin
        out_v_r <= v4_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv5) begin
      next_pot_r <= next_pot;
      out_side_r <= side4_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_side_r.pos.last;
  assign out_tdata  = {(OUT_TDATA_W - 2*VALUE_W - 3*POS_W)'(0),
                       out_side_r.pos.z, out_side_r.pos.y, out_side_r.pos.x,
                       out_side_r.swapped, next_pot_r};

  // a held window beat is not dropped
  `WESU_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_v && !adv2, s1_v)
  // a beat in the last term stage survives an output stall
  `WESU_ASSERT_NEXT(a_s4_hold, clk, rst_n, v4_r && !adv5, v4_r)
  // an advancing stage 2 beat lands in stage 3
  `WESU_ASSERT_NEXT(a_s2_move, clk, rst_n, v2_r && adv3, v3_r)

endmodule
